// File: rtl/ptp_port_state_machine_unit_macros.svh
// Assertion macros for the PTP port state machine unit.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef PTP_PORT_STATE_MACHINE_UNIT_MACROS_SVH
`define PTP_PORT_STATE_MACHINE_UNIT_MACROS_SVH

// Check a consequence in the same cycle.
`define PTPSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the next cycle.
`define PTPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ptpsm_pkg.sv
// Shared types, codes and the port state transition function.
// No dependencies; used by every other file of the block except the macro header.
package ptpsm_pkg;

  localparam int MtDepth  = 8;
  localparam int IdxW     = (MtDepth > 1) ? $clog2(MtDepth) : 1;
  localparam int CntW     = $clog2(MtDepth + 1);
  localparam int ReqW     = 2;
  localparam int EvW      = 4;
  localparam int ClkIdW   = 64;
  localparam int PortNumW = 16;
  localparam int KeyW     = ClkIdW + PortNumW;
  localparam int TimeW    = 64;
  localparam int StW      = 4;
  localparam int KindW    = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int LapW     = 3;
  localparam int RtcW     = 8;
  localparam int NsW      = 30;
  localparam int ProdW    = NsW + RtcW;
  localparam int TmoW     = ProdW + (1 << LapW) - 1;
  localparam int QDepth   = 2;
  localparam int QPtrW    = 1;
  localparam int QCntW    = 2;

  localparam logic [NsW-1:0] NS_PER_SEC = 30'd1000000000;

  localparam logic [StW-1:0] ST_INIT      = 4'd0;
  localparam logic [StW-1:0] ST_FAULTY    = 4'd1;
  localparam logic [StW-1:0] ST_DISABLED  = 4'd2;
  localparam logic [StW-1:0] ST_LISTEN    = 4'd3;
  localparam logic [StW-1:0] ST_PREMASTER = 4'd4;
  localparam logic [StW-1:0] ST_MASTER    = 4'd5;
  localparam logic [StW-1:0] ST_PASSIVE   = 4'd6;
  localparam logic [StW-1:0] ST_UNCAL     = 4'd7;
  localparam logic [StW-1:0] ST_SLAVE     = 4'd8;

  localparam logic [EvW-1:0] EV_INIT       = 4'd0;
  localparam logic [EvW-1:0] EV_FAULT      = 4'd1;
  localparam logic [EvW-1:0] EV_FAULT_CLR  = 4'd2;
  localparam logic [EvW-1:0] EV_ENABLE     = 4'd3;
  localparam logic [EvW-1:0] EV_DISABLE    = 4'd4;
  localparam logic [EvW-1:0] EV_RS_MASTER  = 4'd5;
  localparam logic [EvW-1:0] EV_RS_GM      = 4'd6;
  localparam logic [EvW-1:0] EV_RS_SLAVE   = 4'd7;
  localparam logic [EvW-1:0] EV_RS_PASSIVE = 4'd8;
  localparam logic [EvW-1:0] EV_QUAL_TO    = 4'd9;
  localparam logic [EvW-1:0] EV_SYNC_FAULT = 4'd10;
  localparam logic [EvW-1:0] EV_ANN_TO     = 4'd11;

  localparam logic [ReqW-1:0] REQ_EVENT    = 2'd0;
  localparam logic [ReqW-1:0] REQ_ANNOUNCE = 2'd1;
  localparam logic [ReqW-1:0] REQ_TICK     = 2'd2;

  localparam logic [KindW-1:0] KIND_NOP  = 2'd0;
  localparam logic [KindW-1:0] KIND_EVT  = 2'd1;
  localparam logic [KindW-1:0] KIND_ANN  = 2'd2;
  localparam logic [KindW-1:0] KIND_TICK = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_LOG_ANNOUNCE_PERIOD   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RECEIPT_TIMEOUT_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PEER_DELAY_MODE       = 2'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [EvW-1:0]   event_code;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] tick_time;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_entry_t;

  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  function automatic logic [StW-1:0] next_state(input logic [StW-1:0] s,
                                                input logic [EvW-1:0] ev);
    logic             rs_m;
    logic [StW-1:0]   ns;
    rs_m = (ev == EV_RS_MASTER) || (ev == EV_RS_GM);
    ns   = s;
    case (s)
      ST_INIT: begin
        if (ev == EV_INIT) ns = ST_LISTEN;
        else if (ev == EV_FAULT) ns = ST_FAULTY;
        else if (ev == EV_DISABLE) ns = ST_DISABLED;
      end
      ST_FAULTY: begin
        if (ev == EV_FAULT_CLR) ns = ST_INIT;
      end
      ST_DISABLED: begin
        if (ev == EV_ENABLE) ns = ST_LISTEN;
      end
      ST_LISTEN: begin
        if (rs_m) ns = ST_PREMASTER;
        else if (ev == EV_RS_SLAVE) ns = ST_UNCAL;
        else if (ev == EV_RS_PASSIVE) ns = ST_PASSIVE;
        else if (ev == EV_FAULT) ns = ST_FAULTY;
        else if (ev == EV_DISABLE) ns = ST_DISABLED;
      end
      ST_PREMASTER: begin
        if (ev == EV_QUAL_TO) ns = ST_MASTER;
        else if (ev == EV_RS_SLAVE) ns = ST_UNCAL;
        else if (ev == EV_RS_PASSIVE) ns = ST_PASSIVE;
      end
      ST_MASTER: begin
        if (ev == EV_RS_SLAVE) ns = ST_UNCAL;
        else if (ev == EV_RS_PASSIVE) ns = ST_PASSIVE;
      end
      ST_PASSIVE: begin
        if (rs_m) ns = ST_PREMASTER;
        else if (ev == EV_RS_SLAVE) ns = ST_UNCAL;
      end
      ST_UNCAL: begin
        if (rs_m) ns = ST_PREMASTER;
        else if (ev == EV_RS_PASSIVE) ns = ST_PASSIVE;
        else if (ev == EV_SYNC_FAULT || ev == EV_ANN_TO) ns = ST_LISTEN;
      end
      ST_SLAVE: begin
        if (rs_m) ns = ST_PREMASTER;
        else if (ev == EV_RS_PASSIVE) ns = ST_PASSIVE;
        else if (ev == EV_SYNC_FAULT) ns = ST_UNCAL;
        else if (ev == EV_ANN_TO) ns = ST_LISTEN;
      end
      default: ns = s;
    endcase
    return ns;
  endfunction

endpackage

// File: rtl/ptpsm_if.sv
// Channel interfaces: request input, result output and register writes.
// Depends on ptpsm_pkg for field widths.
interface ptpsm_in_if;
  logic                             valid;
  logic                             ready;
  logic [ptpsm_pkg::ReqW-1:0]       req_type;
  logic [ptpsm_pkg::EvW-1:0]        event_code;
  logic [ptpsm_pkg::ClkIdW-1:0]     source_clock_identity;
  logic [ptpsm_pkg::PortNumW-1:0]   source_port_number;
  logic [ptpsm_pkg::TimeW-1:0]      tick_time;
  modport source (output valid, req_type, event_code, source_clock_identity,
                  source_port_number, tick_time, input ready);
  modport sink (input valid, req_type, event_code, source_clock_identity,
                source_port_number, tick_time, output ready);
endinterface

interface ptpsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptpsm_pkg::StW-1:0]   port_state_now;
  logic                        state_changed;
  logic                        entered_faulty;
  logic                        send_announce_sync;
  logic                        send_delay_request;
  logic                        status;
  modport source (output valid, port_state_now, state_changed, entered_faulty,
                  send_announce_sync, send_delay_request, status, input ready);
  modport sink (input valid, port_state_now, state_changed, entered_faulty,
                send_announce_sync, send_delay_request, status, output ready);
endinterface

interface ptpsm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ptpsm_pkg::CfgIdxW-1:0]   index;
  logic [ptpsm_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/ptp_port_state_machine_unit.sv
// PTP port state machine unit: front stage, command queue and back stage.
// Depends on ptpsm_pkg, ptpsm_if, ptpsm_front, ptpsm_fifo, ptpsm_back and the macro header.
//
// Channels: in_chan takes requests (state event, announce, tick), out_chan gives one
// result per request, cfg_chan writes the three registers (always ready).
// A request transfer lands in the front register, moves through a two-entry queue and
// is carried out by the back stage, which handles one request at a time.
// In the back stage an event passes through an execute state, a tick through a multiply
// and a compare state, and an announce through a read and a compare per table entry
// (up to 8) and an end state; an unknown request goes straight to the result. The
// announce table search, through a registered memory read, makes announces the longest.
// Sustained rate: one request per back-stage pass.
// The front accepts new requests while the back works, until the queue and the front
// register are full.
// Reset: port state Initializing, table empty, last announce time zero, registers at
// their defaults (period 1, timeout count 3, end-to-end delay); no clearing pass.
// A stalled result holds in the output register; the back stage then waits and the
// queue fills.
module ptp_port_state_machine_unit (
  input  logic        clk,
  input  logic        rst_n,
  ptpsm_in_if.sink    in_chan,
  ptpsm_out_if.source out_chan,
  ptpsm_cfg_if.sink   cfg_chan
);
  import ptpsm_pkg::*;

`include "ptp_port_state_machine_unit_macros.svh"

  q_entry_t push;
  q_entry_t head;
  logic     q_full;
  logic     pop;
  cfg_wr_t  cfg_wr;

  assign cfg_chan.ready = 1'b1;
  assign cfg_wr.en      = cfg_chan.valid && cfg_chan.ready;
  assign cfg_wr.index   = cfg_chan.index;
  assign cfg_wr.data    = cfg_chan.data;

  ptpsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .push_o   (push),
    .q_full_i (q_full)
  );

  ptpsm_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  ptpsm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_i   (head),
    .pop_o    (pop),
    .cfg_i    (cfg_wr),
    .out_chan (out_chan)
  );

  `PTPSM_ASSERT_NOW(a_faulty_flag, out_chan.valid && out_chan.entered_faulty, out_chan.state_changed && out_chan.port_state_now == ST_FAULTY, "entered_faulty without a change into Faulty")
  `PTPSM_ASSERT_NOW(a_full_no_move, out_chan.valid && out_chan.status, !out_chan.state_changed && !out_chan.send_announce_sync, "table full result moved the state")
  `PTPSM_ASSERT_NOW(a_one_request, out_chan.valid, !(out_chan.send_announce_sync && out_chan.send_delay_request), "announce and delay request together")
  `PTPSM_ASSERT_NEXT(a_front_hold, push.valid && q_full, push.valid && $stable(push.cmd), "front stage dropped a command while the queue was full")

endmodule

// File: rtl/ptpsm_front.sv
// Front stage: takes request transfers, classifies them into commands, holds one.
// Depends on ptpsm_pkg and ptpsm_in_if.
module ptpsm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  ptpsm_in_if.sink             in_chan,
  output ptpsm_pkg::q_entry_t  push_o,
  input  logic                 q_full_i
);
  import ptpsm_pkg::*;

  logic        hold_valid_r, hold_valid_nxt;
  cmd_t        hold_cmd_r, hold_cmd_nxt;
  logic        take;
  logic [KindW-1:0] kind;

  assign in_chan.ready = !hold_valid_r || !q_full_i;
  assign take          = in_chan.valid && in_chan.ready;
  assign push_o.valid  = hold_valid_r;
  assign push_o.cmd    = hold_cmd_r;

  always_comb begin
    case (in_chan.req_type)
      REQ_EVENT:    kind = KIND_EVT;
      REQ_ANNOUNCE: kind = KIND_ANN;
      REQ_TICK:     kind = KIND_TICK;
      default:      kind = KIND_NOP;
    endcase
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_cmd_nxt   = hold_cmd_r;
    if (hold_valid_r && !q_full_i) hold_valid_nxt = 1'b0;
    if (take) begin
      hold_valid_nxt         = 1'b1;
      hold_cmd_nxt.kind       = kind;
      hold_cmd_nxt.event_code = in_chan.event_code;
      hold_cmd_nxt.key        = {in_chan.source_clock_identity, in_chan.source_port_number};
      hold_cmd_nxt.tick_time  = in_chan.tick_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_cmd_r <= hold_cmd_nxt;
  end

endmodule

// File: rtl/ptpsm_fifo.sv
// Short command queue between the front and back stages.
// Depends on ptpsm_pkg.
module ptpsm_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptpsm_pkg::q_entry_t  push_i,
  output logic                 full_o,
  output ptpsm_pkg::q_entry_t  head_o,
  input  logic                 pop_i
);
  import ptpsm_pkg::*;

  cmd_t              slot_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full_o       = (cnt_r == QCntW'(QDepth));
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && (cnt_r != '0);
  assign head_o.valid = (cnt_r != '0);
  assign head_o.cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) slot_r[wr_ptr_r] <= push_i.cmd;
  end

endmodule

// File: rtl/ptpsm_back.sv
// Back stage: port state, foreign-master table search, timeout check, result register.
// Depends on ptpsm_pkg and ptpsm_out_if.
module ptpsm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ptpsm_pkg::q_entry_t  head_i,
  output logic                 pop_o,
  input  ptpsm_pkg::cfg_wr_t   cfg_i,
  ptpsm_out_if.source          out_chan
);
  import ptpsm_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_ANN_RD   = 4'd2;
  localparam logic [3:0] S_ANN_CMP  = 4'd3;
  localparam logic [3:0] S_ANN_END  = 4'd4;
  localparam logic [3:0] S_TICK_MUL = 4'd5;
  localparam logic [3:0] S_TICK_CMP = 4'd6;
  localparam logic [3:0] S_DONE     = 4'd7;

  logic [3:0]       fsm_r, fsm_nxt;
  logic [StW-1:0]   state_r, state_nxt;
  logic [StW-1:0]   before_r, before_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [CntW-1:0]  idx_r, idx_nxt;
  logic [TimeW-1:0] last_r, last_nxt;
  logic [LapW-1:0]  lap_r, lap_nxt;
  logic [RtcW-1:0]  rtc_r, rtc_nxt;
  logic             pdm_r, pdm_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             found_r, found_nxt;
  logic             ann_r, ann_nxt;
  logic             dreq_r, dreq_nxt;
  logic             status_r, status_nxt;
  logic [ProdW-1:0] prod_r, prod_nxt;
  logic [TimeW-1:0] elapsed_r, elapsed_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [StW-1:0]   ostate_r, ostate_nxt;
  logic             ochg_r, ochg_nxt;
  logic             ofault_r, ofault_nxt;
  logic             oann_r, oann_nxt;
  logic             odreq_r, odreq_nxt;
  logic             ostatus_r, ostatus_nxt;

  logic [KeyW-1:0]  mem [MtDepth];
  logic [KeyW-1:0]  rd_data_r;
  logic             mem_we;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_addr;

  logic [StW-1:0]   ev_state;
  logic [TmoW-1:0]  tmo;
  logic             expired;
  logic [StW-1:0]   tick_state;
  logic             is_slave_like;
  logic             tbl_full;

  assign rd_addr = idx_r[IdxW-1:0];
  assign wr_addr = count_r[IdxW-1:0];

  assign out_chan.valid              = ovalid_r;
  assign out_chan.port_state_now     = ostate_r;
  assign out_chan.state_changed      = ochg_r;
  assign out_chan.entered_faulty     = ofault_r;
  assign out_chan.send_announce_sync = oann_r;
  assign out_chan.send_delay_request = odreq_r;
  assign out_chan.status             = ostatus_r;

  assign ev_state      = next_state(state_r, cmd_r.event_code);
  assign tmo           = TmoW'(prod_r) << lap_r;
  assign is_slave_like = (state_r == ST_SLAVE) || (state_r == ST_UNCAL);
  assign expired       = is_slave_like && (elapsed_r > TimeW'(tmo));
  assign tick_state    = expired ? ST_LISTEN : state_r;
  assign tbl_full      = (count_r >= CntW'(MtDepth));

  always_comb begin
    fsm_nxt     = fsm_r;
    state_nxt   = state_r;
    before_nxt  = before_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    last_nxt    = last_r;
    lap_nxt     = lap_r;
    rtc_nxt     = rtc_r;
    pdm_nxt     = pdm_r;
    cmd_nxt     = cmd_r;
    found_nxt   = found_r;
    ann_nxt     = ann_r;
    dreq_nxt    = dreq_r;
    status_nxt  = status_r;
    prod_nxt    = prod_r;
    elapsed_nxt = elapsed_r;
    ovalid_nxt  = ovalid_r && !out_chan.ready;
    ostate_nxt  = ostate_r;
    ochg_nxt    = ochg_r;
    ofault_nxt  = ofault_r;
    oann_nxt    = oann_r;
    odreq_nxt   = odreq_r;
    ostatus_nxt = ostatus_r;
    mem_we      = 1'b0;
    pop_o       = 1'b0;

    if (cfg_i.en) begin
      case (cfg_i.index)
        CFG_LOG_ANNOUNCE_PERIOD:   lap_nxt = cfg_i.data[LapW-1:0];
        CFG_RECEIPT_TIMEOUT_COUNT: rtc_nxt = cfg_i.data[RtcW-1:0];
        CFG_PEER_DELAY_MODE:       pdm_nxt = cfg_i.data[0];
        default: ;
      endcase
    end

    case (fsm_r)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o      = 1'b1;
          cmd_nxt    = head_i.cmd;
          before_nxt = state_r;
          found_nxt  = 1'b0;
          ann_nxt    = 1'b0;
          dreq_nxt   = 1'b0;
          status_nxt = 1'b0;
          idx_nxt    = '0;
          case (head_i.cmd.kind)
            KIND_EVT:  fsm_nxt = S_EXEC;
            KIND_ANN:  fsm_nxt = S_ANN_RD;
            KIND_TICK: fsm_nxt = S_TICK_MUL;
            default:   fsm_nxt = S_DONE;
          endcase
        end
      end
      S_EXEC: begin
        if (ev_state != state_r) begin
          state_nxt = ev_state;
          if (ev_state == ST_INIT) count_nxt = '0;
          if (ev_state == ST_MASTER) last_nxt = '0;
        end
        fsm_nxt = S_DONE;
      end
      S_ANN_RD: begin
        fsm_nxt = (idx_r == count_r) ? S_ANN_END : S_ANN_CMP;
      end
      S_ANN_CMP: begin
        if (rd_data_r == cmd_r.key) begin
          found_nxt = 1'b1;
          fsm_nxt   = S_ANN_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
          fsm_nxt = S_ANN_RD;
        end
      end
      S_ANN_END: begin
        if (!found_r && tbl_full) begin
          status_nxt = 1'b1;
        end else begin
          if (!found_r) begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (state_r == ST_LISTEN) state_nxt = ST_UNCAL;
        end
        fsm_nxt = S_DONE;
      end
      S_TICK_MUL: begin
        prod_nxt    = ProdW'(NS_PER_SEC) * ProdW'(rtc_r);
        elapsed_nxt = (cmd_r.tick_time >= last_r) ? cmd_r.tick_time - last_r : '0;
        fsm_nxt     = S_TICK_CMP;
      end
      S_TICK_CMP: begin
        state_nxt = tick_state;
        if (tick_state == ST_MASTER) begin
          ann_nxt  = 1'b1;
          last_nxt = cmd_r.tick_time;
        end else if ((tick_state == ST_SLAVE || tick_state == ST_UNCAL) && !pdm_r) begin
          dreq_nxt = 1'b1;
        end
        fsm_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_r || out_chan.ready) begin
          ovalid_nxt  = 1'b1;
          ostate_nxt  = state_r;
          ochg_nxt    = (state_r != before_r);
          ofault_nxt  = (state_r != before_r) && (state_r == ST_FAULTY);
          oann_nxt    = ann_r;
          odreq_nxt   = dreq_r;
          ostatus_nxt = status_r;
          fsm_nxt     = S_IDLE;
        end
      end
      default: fsm_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= cmd_r.key;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r    <= S_IDLE;
      state_r  <= ST_INIT;
      count_r  <= '0;
      last_r   <= '0;
      lap_r    <= LapW'(1);
      rtc_r    <= RtcW'(3);
      pdm_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      fsm_r    <= fsm_nxt;
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
      lap_r    <= lap_nxt;
      rtc_r    <= rtc_nxt;
      pdm_r    <= pdm_nxt;
      ovalid_r <= ovalid_nxt;
    end
    before_r  <= before_nxt;
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    found_r   <= found_nxt;
    ann_r     <= ann_nxt;
    dreq_r    <= dreq_nxt;
    status_r  <= status_nxt;
    prod_r    <= prod_nxt;
    elapsed_r <= elapsed_nxt;
    ostate_r  <= ostate_nxt;
    ochg_r    <= ochg_nxt;
    ofault_r  <= ofault_nxt;
    oann_r    <= oann_nxt;
    odreq_r   <= odreq_nxt;
    ostatus_r <= ostatus_nxt;
  end

endmodule

// File: tb/ptpsm_checker.sv
// Scoreboard for the PTP port state machine unit: predicts every result from the
// accepted requests and register writes and compares it with the result channel.
// Depends on ptpsm_pkg and the channel interfaces in ptpsm_if.
module ptpsm_checker
  import ptpsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ptpsm_in_if         in_mon,
  ptpsm_out_if        out_mon,
  ptpsm_cfg_if        cfg_mon,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count,
  output logic [8:0]  states_seen
);

  typedef struct packed {
    logic [StW-1:0] state;
    logic           changed;
    logic           faulty;
    logic           ann_sync;
    logic           dly_req;
    logic           status;
  } port_result_t;

  port_result_t    expected_results[$];

  logic [LapW-1:0] lap_cfg;
  logic [RtcW-1:0] rtc_cfg;
  logic            pdm_cfg;

  logic [StW-1:0]  port_now;
  logic [KeyW-1:0] master_keys[MtDepth];
  logic [CntW-1:0] master_fill;
  logic [TimeW-1:0] last_ann_ns;

  function automatic logic [StW-1:0] event_target(input logic [StW-1:0] s,
                                                  input logic [EvW-1:0] ev);
    logic [StW-1:0] t;
    t = s;
    case (ev)
      EV_INIT:      if (s == ST_INIT) t = ST_LISTEN;
      EV_FAULT:     if (s == ST_INIT || s == ST_LISTEN) t = ST_FAULTY;
      EV_FAULT_CLR: if (s == ST_FAULTY) t = ST_INIT;
      EV_ENABLE:    if (s == ST_DISABLED) t = ST_LISTEN;
      EV_DISABLE:   if (s == ST_INIT || s == ST_LISTEN) t = ST_DISABLED;
      EV_RS_MASTER, EV_RS_GM: begin
        if (s == ST_LISTEN || s == ST_PASSIVE || s == ST_UNCAL || s == ST_SLAVE)
          t = ST_PREMASTER;
      end
      EV_RS_SLAVE: begin
        if (s == ST_LISTEN || s == ST_PREMASTER || s == ST_MASTER || s == ST_PASSIVE)
          t = ST_UNCAL;
      end
      EV_RS_PASSIVE: begin
        if (s == ST_LISTEN || s == ST_PREMASTER || s == ST_MASTER || s == ST_UNCAL ||
            s == ST_SLAVE)
          t = ST_PASSIVE;
      end
      EV_QUAL_TO:    if (s == ST_PREMASTER) t = ST_MASTER;
      EV_SYNC_FAULT: begin
        if (s == ST_UNCAL) t = ST_LISTEN;
        else if (s == ST_SLAVE) t = ST_UNCAL;
      end
      EV_ANN_TO:     if (s == ST_UNCAL || s == ST_SLAVE) t = ST_LISTEN;
      default: ;
    endcase
    return t;
  endfunction

  task automatic move_to(input logic [StW-1:0] t);
    if (t != port_now) begin
      port_now = t;
      if (t == ST_INIT) master_fill = '0;
      if (t == ST_MASTER) last_ann_ns = '0;
    end
  endtask

  task automatic predict_port_step(input logic [ReqW-1:0] req, input logic [EvW-1:0] ev,
                                   input logic [KeyW-1:0] key, input logic [TimeW-1:0] tt);
    port_result_t     r;
    logic [StW-1:0]   prior;
    logic             hit;
    logic [TimeW-1:0] tmo;
    logic [TimeW-1:0] elapsed;
    int               i;
    r = '0;
    prior = port_now;
    case (req)
      REQ_EVENT: move_to(event_target(port_now, ev));
      REQ_ANNOUNCE: begin
        hit = 1'b0;
        for (i = 0; i < int'(master_fill); i++)
          if (master_keys[i] == key) hit = 1'b1;
        if (!hit) begin
          if (int'(master_fill) < MtDepth) begin
            master_keys[master_fill[IdxW-1:0]] = key;
            master_fill = master_fill + 1'b1;
          end else begin
            r.status = 1'b1;
          end
        end
        if (!r.status && master_fill != 0 && port_now == ST_LISTEN) move_to(ST_UNCAL);
      end
      REQ_TICK: begin
        if (port_now == ST_SLAVE || port_now == ST_UNCAL) begin
          tmo = (64'd1000000000 << lap_cfg) * {56'd0, rtc_cfg};
          elapsed = (tt >= last_ann_ns) ? tt - last_ann_ns : 64'd0;
          if (elapsed > tmo) move_to(ST_LISTEN);
        end
        if (port_now == ST_MASTER) begin
          r.ann_sync = 1'b1;
          last_ann_ns = tt;
        end else if ((port_now == ST_SLAVE || port_now == ST_UNCAL) && !pdm_cfg) begin
          r.dly_req = 1'b1;
        end
      end
      default: ;
    endcase
    r.state = port_now;
    r.changed = (port_now != prior);
    r.faulty = r.changed && (port_now == ST_FAULTY);
    expected_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    port_result_t r;
    if (!rst_n) begin
      lap_cfg = 3'd1;
      rtc_cfg = 8'd3;
      pdm_cfg = 1'b0;
      port_now = ST_INIT;
      master_fill = '0;
      last_ann_ns = '0;
      expected_results.delete();
      fail_count = 0;
      checked_count = 0;
      states_seen = '0;
      pending_count <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_LOG_ANNOUNCE_PERIOD:   lap_cfg = cfg_mon.data[LapW-1:0];
          CFG_RECEIPT_TIMEOUT_COUNT: rtc_cfg = cfg_mon.data[RtcW-1:0];
          CFG_PEER_DELAY_MODE:       pdm_cfg = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting: port_state_now %0d",
                 out_mon.port_state_now);
          fail_count++;
        end else begin
          r = expected_results.pop_front();
          check_field("port_state_now", 8'(r.state), 8'(out_mon.port_state_now));
          check_field("state_changed", 8'(r.changed), 8'(out_mon.state_changed));
          check_field("entered_faulty", 8'(r.faulty), 8'(out_mon.entered_faulty));
          check_field("send_announce_sync", 8'(r.ann_sync), 8'(out_mon.send_announce_sync));
          check_field("send_delay_request", 8'(r.dly_req), 8'(out_mon.send_delay_request));
          check_field("status", 8'(r.status), 8'(out_mon.status));
          states_seen[r.state] = 1'b1;
          checked_count++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_port_step(in_mon.req_type, in_mon.event_code,
                          {in_mon.source_clock_identity, in_mon.source_port_number},
                          in_mon.tick_time);
      pending_count <= expected_results.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the PTP port state machine unit testbench: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on ptpsm_pkg, ptpsm_if, the unit under test and ptpsm_checker.
module tb_top;
  import ptpsm_pkg::*;

  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 65;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 150;
  localparam int PoolSize    = 10;
  localparam logic [CfgIdxW-1:0] CfgUnused = CFG_PEER_DELAY_MODE + 2'd1;

  logic clk;
  logic rst_n;

  ptpsm_in_if  in_chan();
  ptpsm_out_if out_chan();
  ptpsm_cfg_if cfg_chan();

  int         fail_count;
  int         pending_count;
  int         checked_count;
  logic [8:0] states_seen;

  bit         src_idle;
  bit         sink_idle;
  bit         hold_req;
  int         sent_count;
  int         directed_count;
  int         settings_count;
  logic [LapW-1:0]  cur_lap;
  logic [RtcW-1:0]  cur_rtc;
  logic [TimeW-1:0] wall_ns;
  logic [KeyW-1:0]  id_pool[PoolSize];

  ptp_port_state_machine_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ptpsm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .states_seen   (states_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("** ptp_port_state_machine_unit: FAILED **");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic [ReqW-1:0] req, input logic [EvW-1:0] ev,
                           input logic [ClkIdW-1:0] cid, input logic [PortNumW-1:0] pn,
                           input logic [TimeW-1:0] tt);
    int gap;
    if (src_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.req_type <= req;
    in_chan.event_code <= ev;
    in_chan.source_clock_identity <= cid;
    in_chan.source_port_number <= pn;
    in_chan.tick_time <= tt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_event(input logic [EvW-1:0] ev);
    send_item(REQ_EVENT, ev, {$urandom, $urandom}, PortNumW'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_ann(input bit fresh);
    logic [KeyW-1:0] key;
    key = fresh ? {$urandom, $urandom, PortNumW'($urandom)}
                : id_pool[$urandom_range(0, PoolSize - 1)];
    send_item(REQ_ANNOUNCE, EvW'($urandom), key[KeyW-1:PortNumW], key[PortNumW-1:0],
              {$urandom, $urandom});
  endtask

  // Mostly advance a running clock so receipt timeouts come due; some wild times.
  task automatic send_tick();
    logic [TimeW-1:0] period;
    logic [TimeW-1:0] t;
    int pick;
    period = 64'd1000000000 << cur_lap;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      t = {$urandom, $urandom};
    end else if (pick < 10) begin
      t = TimeW'($urandom_range(0, 1000));
    end else begin
      if (pick < 20) wall_ns += period * {56'd0, cur_rtc};
      else wall_ns += (period >> 4) * TimeW'($urandom_range(0, 24));
      t = wall_ns;
    end
    send_item(REQ_TICK, EvW'($urandom), {$urandom, $urandom}, PortNumW'($urandom), t);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [LapW-1:0] lap, input logic [RtcW-1:0] rtc,
                            input logic pdm, input bit touch_unused);
    cfg_write(CFG_LOG_ANNOUNCE_PERIOD, {5'($urandom), lap});
    cfg_write(CFG_RECEIPT_TIMEOUT_COUNT, rtc);
    cfg_write(CFG_PEER_DELAY_MODE, {7'($urandom), pdm});
    if (touch_unused) cfg_write(CfgUnused, CfgDataW'($urandom));
    cfg_chan.valid <= 1'b0;
    cur_lap = lap;
    cur_rtc = rtc;
    settings_count++;
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_episode();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        send_event(EV_INIT);
        send_event($urandom_range(0, 1) ? EV_RS_MASTER : EV_RS_GM);
        send_event(EV_QUAL_TO);
        n = $urandom_range(1, 4);
        repeat (n) send_tick();
      end
      2, 3, 4: begin
        send_event(EV_INIT);
        n = $urandom_range(1, 3);
        repeat (n) send_ann($urandom_range(0, 3) == 0);
        n = $urandom_range(1, 8);
        repeat (n) send_tick();
        if ($urandom_range(0, 2) == 0)
          send_event($urandom_range(0, 1) ? EV_SYNC_FAULT : EV_ANN_TO);
      end
      5: begin
        send_event($urandom_range(0, 1) ? EV_FAULT : EV_DISABLE);
        send_event(EV_FAULT_CLR);
        send_event(EV_ENABLE);
      end
      6: begin
        n = $urandom_range(2, 10);
        repeat (n) send_ann(1'b1);
      end
      7: begin
        n = $urandom_range(2, 6);
        repeat (n) send_event(EvW'($urandom_range(EV_RS_MASTER, EV_ANN_TO)));
      end
      default: begin
        n = $urandom_range(1, 5);
        repeat (n)
          send_item(ReqW'($urandom_range(0, 3)), EvW'($urandom_range(0, 15)),
                    {$urandom, $urandom}, PortNumW'($urandom), {$urandom, $urandom});
      end
    endcase
  endtask

  initial begin : stimulus
    int ph;
    int phase_end;
    logic [LapW-1:0] lap;
    logic [RtcW-1:0] rtc;
    logic pdm;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.req_type <= '0;
    in_chan.event_code <= '0;
    in_chan.source_clock_identity <= '0;
    in_chan.source_port_number <= '0;
    in_chan.tick_time <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= '0;
    cfg_chan.data <= '0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    hold_req = 1'b0;
    sent_count = 0;
    settings_count = 1;
    cur_lap = 3'd1;
    cur_rtc = 8'd3;
    wall_ns = '0;
    for (int i = 0; i < PoolSize; i++)
      id_pool[i] = {$urandom, $urandom, PortNumW'($urandom)};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk at the reset register values.
    send_item(REQ_TICK, EV_INIT, '0, '0, '0);
    send_item(ReqW'(REQ_TICK + 2'd1), EvW'(15), '1, '1, '1);
    send_item(REQ_ANNOUNCE, EV_INIT, '0, '0, '0);
    send_event(EV_FAULT);
    send_event(EV_FAULT_CLR);
    send_event(EV_DISABLE);
    send_event(EV_ENABLE);
    send_item(REQ_ANNOUNCE, EV_INIT, '1, '1, '0);
    send_item(REQ_TICK, EV_INIT, '0, '0, 64'd6000000000);
    send_item(REQ_TICK, EV_INIT, '0, '0, 64'd6000000001);
    send_item(REQ_ANNOUNCE, EV_INIT, '1, '1, '0);
    send_event(EV_RS_MASTER);
    send_event(EV_QUAL_TO);
    send_item(REQ_TICK, EV_INIT, '0, '0, '1);
    send_event(EV_RS_SLAVE);
    send_item(REQ_TICK, EV_INIT, '0, '0, 64'd5);
    send_event(EV_ANN_TO);
    send_event(EV_RS_GM);
    send_event(EV_RS_PASSIVE);
    repeat (8) send_ann(1'b1);
    directed_count = sent_count;
    drain();

    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin lap = 3'd0; rtc = 8'd1;   pdm = 1'b0; end
        1: begin lap = 3'd4; rtc = 8'd255; pdm = 1'b1; end
        2: begin lap = 3'd2; rtc = 8'd2;   pdm = 1'b0; end
        3: begin lap = 3'd7; rtc = 8'd0;   pdm = 1'b1; end
        4: begin lap = 3'd5; rtc = 8'd7;   pdm = 1'b0; end
        5: begin lap = 3'd6; rtc = 8'd1;   pdm = 1'b0; end
        default: begin
          lap = LapW'($urandom_range(0, 4));
          rtc = RtcW'($urandom_range(1, 255));
          pdm = 1'($urandom_range(0, 1));
        end
      endcase
      if (ph == NumPhases - 1) begin
        src_idle = 1'b0;
        sink_idle = 1'b0;
      end
      set_config(lap, rtc, pdm, ph == 4);
      if (ph == 1) hold_req = 1'b1;
      phase_end = sent_count + PhaseItems;
      while (sent_count < phase_end) run_episode();
      drain();
    end

    $display("Run covered %0d requests (%0d directed) over %0d register settings,",
             sent_count, directed_count, settings_count);
    $display("with %0d results checked; port states reached (one bit per state): %b",
             checked_count, states_seen);
    if (fail_count == 0) begin
      $display("** ptp_port_state_machine_unit: PASSED **");
    end else begin
      $display("** ptp_port_state_machine_unit: FAILED **");
    end
    $finish;
  end

endmodule
